FILE: design/wde_pkg.sv
package wde_pkg;

  // default table sizes
  localparam int MAX_SHAFTS_D   = 32;
  localparam int MAX_TREADLES_D = 32;
  localparam int MAX_THREADS_D  = 1024;
  localparam int MAX_COLORS_D   = 256;

  // limits are compared in this width, wide enough for every legal maximum
  localparam int LIM_W  = 13;
  // command payload widths cover the largest legal table geometry
  localparam int ADDR_W = 12;
  localparam int DATA_W = 10;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [2:0] OP_TIEUP   = 3'd0;
  localparam logic [2:0] OP_THREAD  = 3'd1;
  localparam logic [2:0] OP_TREADLE = 3'd2;
  localparam logic [2:0] OP_WCOLOR  = 3'd3;
  localparam logic [2:0] OP_FCOLOR  = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_VALUE = 2'd2;

  localparam logic [2:0] CFG_SHAFTS   = 3'd0;
  localparam logic [2:0] CFG_TREADLES = 3'd1;
  localparam logic [2:0] CFG_WARP     = 3'd2;
  localparam logic [2:0] CFG_WEFT     = 3'd3;
  localparam logic [2:0] CFG_COLORS   = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [9:0]        col;
    logic [9:0]        row;
  } wde_cmd_t;

  function automatic logic [LIM_W-1:0] cap_lim(input logic [LIM_W-1:0] cnt,
                                              input logic [LIM_W-1:0] lim);
    return (cnt > lim) ? lim : cnt;
  endfunction

endpackage

FILE: design/wde_front.sv
module wde_front import wde_pkg::*; #(
  parameter int MAX_SHAFTS   = MAX_SHAFTS_D,
  parameter int MAX_TREADLES = MAX_TREADLES_D,
  parameter int MAX_THREADS  = MAX_THREADS_D,
  parameter int MAX_COLORS   = MAX_COLORS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic [2:0]  in_opcode,
  input  logic [10:0] in_entry_index,
  input  logic [8:0]  in_entry_value,
  input  logic [9:0]  in_column,
  input  logic [9:0]  in_row,
  output wde_cmd_t    cmd
);

  localparam int SW = $clog2(MAX_SHAFTS);
  localparam int TW = $clog2(MAX_TREADLES);

  logic [5:0]  shaft_count_r;
  logic [5:0]  treadle_count_r;
  logic [10:0] warp_count_r;
  logic [10:0] weft_count_r;
  logic [8:0]  color_count_r;

  logic [LIM_W-1:0] ns, nt, nwarp, nweft, nc;
  logic [LIM_W-1:0] lim_i, lim_v, idx_e, val_e, idx_m1, val_m1;
  logic [LIM_W-1:0] ns_val, nt_val, nt_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shaft_count_r   <= 6'd1;
      treadle_count_r <= 6'd1;
      warp_count_r    <= 11'd1;
      weft_count_r    <= 11'd1;
      color_count_r   <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHAFTS:   shaft_count_r   <= cfg_data[5:0];
        CFG_TREADLES: treadle_count_r <= cfg_data[5:0];
        CFG_WARP:     warp_count_r    <= cfg_data;
        CFG_WEFT:     weft_count_r    <= cfg_data;
        CFG_COLORS:   color_count_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign ns    = cap_lim(LIM_W'(shaft_count_r), LIM_W'(MAX_SHAFTS));
  assign nt    = cap_lim(LIM_W'(treadle_count_r), LIM_W'(MAX_TREADLES));
  assign nwarp = cap_lim(LIM_W'(warp_count_r), LIM_W'(MAX_THREADS));
  assign nweft = cap_lim(LIM_W'(weft_count_r), LIM_W'(MAX_THREADS));
  assign nc    = cap_lim(LIM_W'(color_count_r), LIM_W'(MAX_COLORS));

  assign idx_e  = LIM_W'(in_entry_index);
  assign val_e  = LIM_W'(in_entry_value);
  assign idx_m1 = idx_e - LIM_W'(1);
  assign val_m1 = val_e - LIM_W'(1);
  assign ns_val = ns - val_e;
  assign nt_val = nt - val_e;
  assign nt_idx = nt - idx_e;

  always_comb begin
    lim_i = '0;
    lim_v = '0;
    case (in_opcode)
      OP_TIEUP:   begin lim_i = nt;    lim_v = ns; end
      OP_THREAD:  begin lim_i = nwarp; lim_v = ns; end
      OP_TREADLE: begin lim_i = nweft; lim_v = nt; end
      OP_WCOLOR:  begin lim_i = nwarp; lim_v = nc; end
      OP_FCOLOR:  begin lim_i = nweft; lim_v = nc; end
      default: ;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.op     = in_opcode;
    cmd.col    = in_column;
    cmd.row    = in_row;
    cmd.status = ST_OK;
    cmd.addr   = ADDR_W'(idx_m1);
    case (in_opcode)
      OP_TIEUP, OP_THREAD, OP_TREADLE, OP_WCOLOR, OP_FCOLOR: begin
        // index checked before value
        if (idx_e == '0 || idx_e > lim_i) begin
          cmd.status = ST_INDEX;
        end else if (val_e == '0 || val_e > lim_v) begin
          cmd.status = ST_VALUE;
        end
        case (in_opcode)
          OP_TIEUP:   cmd.addr = ADDR_W'({nt_idx[TW-1:0], ns_val[SW-1:0]});
          OP_THREAD:  cmd.data = DATA_W'(ns_val);
          OP_TREADLE: cmd.data = DATA_W'(nt_val);
          default:    cmd.data = DATA_W'(val_m1);
        endcase
      end
      OP_QUERY: begin
        if (LIM_W'(in_column) >= nwarp || LIM_W'(in_row) >= nweft) begin
          cmd.status = ST_INDEX;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: design/wde_queue.sv
module wde_queue import wde_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  wde_cmd_t push_data,
  input  logic     pop,
  output wde_cmd_t pop_data,
  output logic     empty,
  output logic     full
);

  wde_cmd_t        slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + (Q_AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (Q_AW+1)'(1);
      end
    end
  end

endmodule

FILE: design/wde_back.sv
module wde_back import wde_pkg::*; #(
  parameter int MAX_SHAFTS   = MAX_SHAFTS_D,
  parameter int MAX_TREADLES = MAX_TREADLES_D,
  parameter int MAX_THREADS  = MAX_THREADS_D,
  parameter int MAX_COLORS   = MAX_COLORS_D
) (
  input  logic       clk,
  input  logic       rst_n,
  input  wde_cmd_t   cmd,
  input  logic       q_empty,
  output logic       pop,
  output logic       clearing,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic       out_warp_on_top,
  output logic [8:0] out_yarn_color
);

  localparam int SW        = $clog2(MAX_SHAFTS);
  localparam int TW        = $clog2(MAX_TREADLES);
  localparam int TA        = $clog2(MAX_THREADS);
  localparam int CLW       = $clog2(MAX_COLORS);
  localparam int TIE_DEPTH = 1 << (TW + SW);
  localparam int CLR_DEPTH = (MAX_THREADS > TIE_DEPTH) ? MAX_THREADS : TIE_DEPTH;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  logic [SW-1:0]  shaft_mem   [MAX_THREADS];
  logic [TW-1:0]  treadle_mem [MAX_THREADS];
  logic [CLW-1:0] wcol_mem    [MAX_THREADS];
  logic [CLW-1:0] fcol_mem    [MAX_THREADS];
  logic           tie_mem     [TIE_DEPTH];

  logic              clearing_r;
  logic [CLR_AW-1:0] clr_addr_r;
  logic              clr_thr;

  logic              ld_ok;
  logic [TA-1:0]     thr_wa, col_a, row_a;
  logic              sh_we, tr_we, wc_we, fc_we, tie_we, tie_wd;
  logic [SW-1:0]     sh_wd;
  logic [TW-1:0]     tr_wd;
  logic [CLW-1:0]    col_wd;
  logic [TW+SW-1:0]  tie_wa;

  logic              s1_vld_r, s1_query_r;
  logic [1:0]        s1_status_r;
  logic [SW-1:0]     sh_rd_r;
  logic [TW-1:0]     tr_rd_r;
  logic [CLW-1:0]    wcol_rd_r, fcol_rd_r;

  logic              s2_vld_r, s2_query_r;
  logic [1:0]        s2_status_r;
  logic              tie_rd_r;
  logic [CLW-1:0]    wcol_s2_r, fcol_s2_r;
  logic [CLW-1:0]    sel_col;
  logic              hit;

  logic              out_valid_r, out_top_r;
  logic [1:0]        out_status_r;
  logic [8:0]        out_color_r;

  assign clearing = clearing_r;
  assign pop      = !q_empty && !clearing_r;
  assign ld_ok    = pop && (cmd.status == ST_OK);
  assign clr_thr  = ({1'b0, clr_addr_r} < (CLR_AW+1)'(MAX_THREADS));

  // sweep zeroes every table after reset, loads write through the same port
  assign thr_wa = clearing_r ? TA'(clr_addr_r) : cmd.addr[TA-1:0];
  assign col_a  = TA'(cmd.col);
  assign row_a  = TA'(cmd.row);
  assign sh_we  = clearing_r ? clr_thr : (ld_ok && cmd.op == OP_THREAD);
  assign tr_we  = clearing_r ? clr_thr : (ld_ok && cmd.op == OP_TREADLE);
  assign wc_we  = clearing_r ? clr_thr : (ld_ok && cmd.op == OP_WCOLOR);
  assign fc_we  = clearing_r ? clr_thr : (ld_ok && cmd.op == OP_FCOLOR);
  assign sh_wd  = clearing_r ? '0 : cmd.data[SW-1:0];
  assign tr_wd  = clearing_r ? '0 : cmd.data[TW-1:0];
  assign col_wd = clearing_r ? '0 : cmd.data[CLW-1:0];
  assign tie_we = clearing_r || (ld_ok && cmd.op == OP_TIEUP);
  assign tie_wa = clearing_r ? (TW+SW)'(clr_addr_r) : cmd.addr[TW+SW-1:0];
  assign tie_wd = !clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + CLR_AW'(1);
      if (clr_addr_r == CLR_AW'(CLR_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sh_we) shaft_mem[thr_wa] <= sh_wd;
    sh_rd_r <= shaft_mem[col_a];
  end

  always_ff @(posedge clk) begin
    if (tr_we) treadle_mem[thr_wa] <= tr_wd;
    tr_rd_r <= treadle_mem[row_a];
  end

  always_ff @(posedge clk) begin
    if (wc_we) wcol_mem[thr_wa] <= col_wd;
    wcol_rd_r <= wcol_mem[col_a];
  end

  always_ff @(posedge clk) begin
    if (fc_we) fcol_mem[thr_wa] <= col_wd;
    fcol_rd_r <= fcol_mem[row_a];
  end

  // second lookup: tie-up cell at (treadle slot, shaft slot)
  always_ff @(posedge clk) begin
    if (tie_we) tie_mem[tie_wa] <= tie_wd;
    tie_rd_r <= tie_mem[{tr_rd_r, sh_rd_r}];
  end

  always_ff @(posedge clk) begin
    s1_query_r  <= (cmd.op == OP_QUERY);
    s1_status_r <= cmd.status;
    s2_query_r  <= s1_query_r;
    s2_status_r <= s1_status_r;
    wcol_s2_r   <= wcol_rd_r;
    fcol_s2_r   <= fcol_rd_r;
  end

  assign hit     = s2_query_r && (s2_status_r == ST_OK);
  assign sel_col = tie_rd_r ? wcol_s2_r : fcol_s2_r;

  always_ff @(posedge clk) begin
    out_status_r <= s2_status_r;
    out_top_r    <= hit && tie_rd_r;
    out_color_r  <= hit ? 9'({1'b0, sel_col} + (CLW+1)'(1)) : 9'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= pop;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_warp_on_top = out_top_r;
  assign out_yarn_color  = out_color_r;

endmodule

FILE: design/weave_drawdown_engine.sv
// channel   ports                                   handshake
// input     start, busy, in_opcode .. in_row        beat taken when start && !busy
// result    out_valid, out_status .. out_yarn_color one-cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_index/data    beat taken when cfg_valid && cfg_ready
//
// one item a cycle once running, while busy is low; each result follows its beat through
// the queue hop, table read, tie-up read and output register
// after reset a clearing pass zeroes the tables, one entry a cycle, over
// max(MAX_THREADS, 2**(clog2 shafts + clog2 treadles)) entries (1024 by default)
// with busy held high; config writes are taken throughout
// busy also rises when the front/back queue is full; results cannot be stalled
module weave_drawdown_engine import wde_pkg::*; #(
  parameter int MAX_SHAFTS   = MAX_SHAFTS_D,
  parameter int MAX_TREADLES = MAX_TREADLES_D,
  parameter int MAX_THREADS  = MAX_THREADS_D,
  parameter int MAX_COLORS   = MAX_COLORS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [10:0] in_entry_index,
  input  logic [8:0]  in_entry_value,
  input  logic [9:0]  in_column,
  input  logic [9:0]  in_row,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_warp_on_top,
  output logic [8:0]  out_yarn_color,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  wde_cmd_t front_cmd;
  wde_cmd_t back_cmd;
  logic     q_empty, q_full, pop, clearing, accept;

  assign cfg_ready = 1'b1;
  assign busy      = clearing || q_full;
  assign accept    = start && !busy;

  wde_front #(
    .MAX_SHAFTS  (MAX_SHAFTS),
    .MAX_TREADLES(MAX_TREADLES),
    .MAX_THREADS (MAX_THREADS),
    .MAX_COLORS  (MAX_COLORS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_opcode     (in_opcode),
    .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value),
    .in_column     (in_column),
    .in_row        (in_row),
    .cmd           (front_cmd)
  );

  wde_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data(front_cmd),
    .pop      (pop),
    .pop_data (back_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  wde_back #(
    .MAX_SHAFTS  (MAX_SHAFTS),
    .MAX_TREADLES(MAX_TREADLES),
    .MAX_THREADS (MAX_THREADS),
    .MAX_COLORS  (MAX_COLORS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (back_cmd),
    .q_empty        (q_empty),
    .pop            (pop),
    .clearing       (clearing),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_warp_on_top(out_warp_on_top),
    .out_yarn_color (out_yarn_color)
  );

endmodule

FILE: design/wde_checker.sv
module wde_prop_checker import wde_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic        out_warp_on_top,
  input logic [8:0]  out_yarn_color
);

  // every accepted beat gives its result after the queue hop and the back-end pipeline
  a_beat_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted beat produced no result");

  a_result_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without an accepted beat");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_INDEX ||
                   out_status == ST_VALUE))
    else $error("undefined status code");

  // a failed item never reports a cell
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (!out_warp_on_top && out_yarn_color == 9'd0))
    else $error("error result carries cell data");

  a_top_has_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_warp_on_top) |-> (out_yarn_color != 9'd0))
    else $error("warp on top without a colour");

endmodule

bind weave_drawdown_engine wde_prop_checker u_wde_checker (.*);
